@@ hw/rtl/ipid_pkg.sv @@
// shared types and constants of the incremental pid step unit
package ipid_pkg;

  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned LIMIT_W = 31;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned ERR_W   = SAMPLE_W + 1;
  localparam int unsigned DP_W    = ERR_W + 1;
  localparam int unsigned DD_W    = ERR_W + 2;
  localparam int unsigned OUT_W   = 32;
  localparam int unsigned SUM_W   = 36;
  localparam int unsigned FRAC_W  = 8;
  localparam int unsigned DATA_W  = LIMIT_W;
  localparam int unsigned INDEX_W = 3;

  localparam logic [INDEX_W-1:0] REG_GAIN_PROP   = 3'd0;
  localparam logic [INDEX_W-1:0] REG_GAIN_INTEG  = 3'd1;
  localparam logic [INDEX_W-1:0] REG_GAIN_DERIV  = 3'd2;
  localparam logic [INDEX_W-1:0] REG_LIMIT_OUT   = 3'd3;
  localparam logic [INDEX_W-1:0] REG_LIMIT_INTEG = 3'd4;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_prop;
    logic signed [GAIN_W-1:0] gain_integ;
    logic signed [GAIN_W-1:0] gain_deriv;
    logic [LIMIT_W-1:0]       limit_out;
    logic [LIMIT_W-1:0]       limit_integ;
  } cfg_t;

  // error terms handed from the front stage to the gain stage
  typedef struct packed {
    logic                   clr;
    logic signed [ERR_W-1:0] e0;
    logic signed [DP_W-1:0]  dp;
    logic signed [DD_W-1:0]  dd;
  } terms_t;

endpackage

@@ hw/rtl/ipid_if.sv @@
// valid/ready channels for samples and results
interface ipid_sample_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [ipid_pkg::SAMPLE_W-1:0]    setpoint;
  logic signed [ipid_pkg::SAMPLE_W-1:0]    measured;
  logic                                    clear_history;

  modport source (output valid, output setpoint, output measured, output clear_history,
                  input ready);
  modport sink (input valid, input setpoint, input measured, input clear_history,
                output ready);
endinterface

interface ipid_result_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ipid_pkg::OUT_W-1:0]    increment;

  modport source (output valid, output increment, input ready);
  modport sink (input valid, input increment, output ready);
endinterface

@@ hw/rtl/ipid_front.sv @@
// error history and difference terms, registered at sample transfer
module ipid_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 load,
  input  logic signed [ipid_pkg::SAMPLE_W-1:0] setpoint,
  input  logic signed [ipid_pkg::SAMPLE_W-1:0] measured,
  input  logic                                 clear_history,
  output ipid_pkg::terms_t                     terms
);

  logic signed [ipid_pkg::ERR_W-1:0] err_last;
  logic signed [ipid_pkg::ERR_W-1:0] err_before_last;
  logic signed [ipid_pkg::ERR_W-1:0] e0;
  logic signed [ipid_pkg::DP_W-1:0]  dp;
  logic signed [ipid_pkg::DD_W-1:0]  dd;

  assign e0 = ipid_pkg::ERR_W'(setpoint) - ipid_pkg::ERR_W'(measured);
  assign dp = ipid_pkg::DP_W'(e0) - ipid_pkg::DP_W'(err_last);
  assign dd = ipid_pkg::DD_W'(e0) - (ipid_pkg::DD_W'(err_last) <<< 1)
              + ipid_pkg::DD_W'(err_before_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      err_last        <= '0;
      err_before_last <= '0;
    end else if (load) begin
      if (clear_history) begin
        err_last        <= '0;
        err_before_last <= '0;
      end else begin
        err_last        <= e0;
        err_before_last <= err_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      terms.clr <= clear_history;
      terms.e0  <= e0;
      terms.dp  <= dp;
      terms.dd  <= dd;
    end
  end

endmodule

@@ hw/rtl/ipid_gain.sv @@
// gain products, clamps and saturation into the result register
module ipid_gain (
  input  logic                              clk,
  input  logic                              load,
  input  ipid_pkg::cfg_t                    cfg,
  input  ipid_pkg::terms_t                  terms,
  output logic signed [ipid_pkg::OUT_W-1:0] increment
);

  localparam logic signed [ipid_pkg::SUM_W-1:0] SAT_MAX =
    ipid_pkg::SUM_W'(64'sd2147483647);
  localparam logic signed [ipid_pkg::SUM_W-1:0] SAT_MIN =
    ipid_pkg::SUM_W'(-64'sd2147483648);

  function automatic logic signed [ipid_pkg::SUM_W-1:0] clamp_sym(
    input logic signed [ipid_pkg::SUM_W-1:0] x,
    input logic [ipid_pkg::LIMIT_W-1:0]      lim
  );
    logic signed [ipid_pkg::SUM_W-1:0] lim_s;
    logic signed [ipid_pkg::SUM_W-1:0] res;
    lim_s = $signed(ipid_pkg::SUM_W'(lim));
    res   = x;
    if (lim != '0) begin
      if (x > lim_s) res = lim_s;
      else if (x < -lim_s) res = -lim_s;
    end
    return res;
  endfunction

  logic signed [ipid_pkg::GAIN_W+ipid_pkg::DP_W-1:0]  prod_p;
  logic signed [ipid_pkg::GAIN_W+ipid_pkg::ERR_W-1:0] prod_i;
  logic signed [ipid_pkg::GAIN_W+ipid_pkg::DD_W-1:0]  prod_d;
  logic signed [ipid_pkg::SUM_W-1:0] term_p;
  logic signed [ipid_pkg::SUM_W-1:0] term_i;
  logic signed [ipid_pkg::SUM_W-1:0] term_d;
  logic signed [ipid_pkg::SUM_W-1:0] sum;
  logic signed [ipid_pkg::SUM_W-1:0] sum_sat;
  logic signed [ipid_pkg::SUM_W-1:0] sum_lim;
  logic signed [ipid_pkg::OUT_W-1:0] increment_next;

  assign prod_p = cfg.gain_prop * terms.dp;
  assign prod_i = cfg.gain_integ * terms.e0;
  assign prod_d = cfg.gain_deriv * terms.dd;

  // arithmetic shift rounds toward minus infinity
  assign term_p = ipid_pkg::SUM_W'(prod_p >>> ipid_pkg::FRAC_W);
  assign term_i = clamp_sym(ipid_pkg::SUM_W'(prod_i >>> ipid_pkg::FRAC_W), cfg.limit_integ);
  assign term_d = ipid_pkg::SUM_W'(prod_d >>> ipid_pkg::FRAC_W);

  assign sum = term_p + term_i + term_d;

  always_comb begin
    if (sum > SAT_MAX) sum_sat = SAT_MAX;
    else if (sum < SAT_MIN) sum_sat = SAT_MIN;
    else sum_sat = sum;
    sum_lim = clamp_sym(sum_sat, cfg.limit_out);
    increment_next = terms.clr ? '0 : sum_lim[ipid_pkg::OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (load) increment <= increment_next;
  end

endmodule

@@ hw/rtl/incremental_pid_step_unit.sv @@
// incremental pid step unit: configuration registers, pipeline control and stages
// a sample's terms are registered in the front stage, then its result in the gain stage's output register
// throughput: one sample per cycle while result.ready is high, set by the two-stage pipeline (front, gain)
// a result waiting at the output does not block the front stage while it is empty
// reset clears the gains, limits, error history and both stage valid flags
module incremental_pid_step_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [ipid_pkg::INDEX_W-1:0]        wr_index,
  input  logic [ipid_pkg::DATA_W-1:0]         wr_data,
  ipid_sample_if.sink                         sample,
  ipid_result_if.source                       result
);

  ipid_pkg::cfg_t   cfg;
  ipid_pkg::terms_t terms;

  logic terms_valid;
  logic out_valid;
  logic sample_take;
  logic terms_move;

  // configuration writes, bits above a register's width are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (wr_index)
        ipid_pkg::REG_GAIN_PROP:   cfg.gain_prop   <= wr_data[ipid_pkg::GAIN_W-1:0];
        ipid_pkg::REG_GAIN_INTEG:  cfg.gain_integ  <= wr_data[ipid_pkg::GAIN_W-1:0];
        ipid_pkg::REG_GAIN_DERIV:  cfg.gain_deriv  <= wr_data[ipid_pkg::GAIN_W-1:0];
        ipid_pkg::REG_LIMIT_OUT:   cfg.limit_out   <= wr_data[ipid_pkg::LIMIT_W-1:0];
        ipid_pkg::REG_LIMIT_INTEG: cfg.limit_integ <= wr_data[ipid_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // terms move on when the output register is empty or being drained
  assign terms_move   = terms_valid && (!out_valid || result.ready);
  assign sample.ready = !terms_valid || !out_valid || result.ready;
  assign sample_take  = sample.valid && sample.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      terms_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (sample_take) terms_valid <= 1'b1;
      else if (terms_move) terms_valid <= 1'b0;

      if (terms_move) out_valid <= 1'b1;
      else if (result.ready) out_valid <= 1'b0;
    end
  end

  // error history is updated at each sample transfer
  ipid_front u_front (
    .clk           (clk),
    .rst           (rst),
    .load          (sample_take),
    .setpoint      (sample.setpoint),
    .measured      (sample.measured),
    .clear_history (sample.clear_history),
    .terms         (terms)
  );

  // products, integral clamp, saturation and output clamp
  ipid_gain u_gain (
    .clk       (clk),
    .load      (terms_move),
    .cfg       (cfg),
    .terms     (terms),
    .increment (result.increment)
  );

  assign result.valid = out_valid;

endmodule
